FILE: rtl/core/chps_pkg.sv
package chps_pkg;

  localparam int unsigned CountBits = 24;
  localparam int unsigned OutBits   = 24;
  localparam int unsigned ScaleBits = 17;
  localparam int unsigned BinBits   = 8;
  localparam int unsigned NumBins   = 1 << BinBits;
  localparam int unsigned WideBits  = (CountBits > OutBits) ? CountBits : OutBits;

  localparam logic [OutBits-1:0]   OutMax     = {OutBits{1'b1}};
  localparam logic [CountBits-1:0] CountLimit = {CountBits{1'b1}};

  localparam logic [1:0] FuncClear = 2'd0;
  localparam logic [1:0] FuncAdd   = 2'd1;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_GRAY  = 2'd3
  } chan_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ADD,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [BinBits-1:0]   addr;
    logic [CountBits-1:0] wdata;
  } bin_mem_req_t;

  function automatic logic [OutBits-1:0] clip_out(input logic [CountBits-1:0] v);
    logic [WideBits-1:0] w;
    w = WideBits'(v);
    if (w > WideBits'(OutMax)) begin
      return OutMax;
    end
    return w[OutBits-1:0];
  endfunction

  // A peak at or above each threshold moves the scale up by one decade.
  function automatic logic [ScaleBits-1:0] decade_scale(input logic [CountBits-1:0] peak);
    logic [31:0] w;
    w = 32'(peak);
    priority if (w >= 32'd2560000) begin
      return 17'd100000;
    end else if (w >= 32'd256000) begin
      return 17'd10000;
    end else if (w >= 32'd25600) begin
      return 17'd1000;
    end else if (w >= 32'd2560) begin
      return 17'd100;
    end else if (w >= 32'd256) begin
      return 17'd10;
    end else begin
      return 17'd1;
    end
  endfunction

  function automatic logic [BinBits-1:0] channel_value(input chan_e mode,
                                                       input logic [23:0] rgb);
    logic [12:0] luma;
    luma = 13'(rgb[23:16]) * 13'd11 + 13'(rgb[15:8]) * 13'd16 + 13'(rgb[7:0]) * 13'd5;
    unique case (mode)
      CH_RED:   return rgb[23:16];
      CH_GREEN: return rgb[15:8];
      CH_BLUE:  return rgb[7:0];
      CH_GRAY:  return luma[12:5];
      default:  return rgb[23:16];
    endcase
  endfunction

endpackage

FILE: rtl/core/chps_bin_mem.sv
module chps_bin_mem (
  input  logic                             clk_i,
  input  chps_pkg::bin_mem_req_t           req_i,
  output logic [chps_pkg::CountBits-1:0]   rdata_o
);

  logic [chps_pkg::CountBits-1:0] mem [chps_pkg::NumBins];
  logic [chps_pkg::CountBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/channel_histogram_peak_scale_unit.sv
// A 256-bin histogram of one channel of packed RGB pixels, with a running peak
// and a decade axis scale reported with every result. Each transaction passes
// through acceptance, a read of the single-port bin memory, the update and
// write-back of the bin and peak, and the loading of the output register once
// any earlier result has been taken; the next transaction is accepted after
// that, even while its result still waits. A clear empties all bins at once
// through per-bin valid bits, so no clearing pass is needed after reset.
module channel_histogram_peak_scale_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [23:0] pixel_rgb_i,
  input  logic [7:0]  bin_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] bin_count_o,
  output logic [23:0] peak_count_o,
  output logic [16:0] axis_scale_o
);

  chps_pkg::state_e state_q, state_d;
  chps_pkg::chan_e  chan_q;
  chps_pkg::op_e    op_q, op_in;

  logic [chps_pkg::BinBits-1:0]   addr_q, addr_in;
  logic [chps_pkg::NumBins-1:0]   bin_valid_q;
  logic [chps_pkg::CountBits-1:0] peak_q, count_q, count_d, rdata;
  logic                           out_valid_q;
  logic [chps_pkg::OutBits-1:0]   bin_count_q, peak_count_q;
  logic [chps_pkg::ScaleBits-1:0] axis_scale_q;
  logic                           accept, do_update, load_out;

  chps_pkg::bin_mem_req_t mem_req;

  always_comb begin
    unique case (func_i)
      chps_pkg::FuncClear: op_in = chps_pkg::OP_CLEAR;
      chps_pkg::FuncAdd:   op_in = chps_pkg::OP_ADD;
      default:             op_in = chps_pkg::OP_READ;
    endcase
    addr_in = (op_in == chps_pkg::OP_ADD) ? chps_pkg::channel_value(chan_q, pixel_rgb_i)
                                          : bin_index_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chps_pkg::ST_IDLE:   if (in_valid_i) state_d = chps_pkg::ST_READ;
      chps_pkg::ST_READ:   state_d = chps_pkg::ST_UPDATE;
      chps_pkg::ST_UPDATE: state_d = chps_pkg::ST_OUT;
      chps_pkg::ST_OUT:    if (!out_valid_q || out_ready_i) state_d = chps_pkg::ST_IDLE;
      default:             state_d = chps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == chps_pkg::ST_IDLE);
    accept     = in_ready_o && in_valid_i;
    do_update  = (state_q == chps_pkg::ST_UPDATE);
    load_out   = (state_q == chps_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    unique case (op_q)
      chps_pkg::OP_CLEAR: count_d = '0;
      chps_pkg::OP_ADD: begin
        if (!bin_valid_q[addr_q]) begin
          count_d = chps_pkg::CountBits'(1);
        end else if (rdata < chps_pkg::CountLimit) begin
          count_d = rdata + chps_pkg::CountBits'(1);
        end else begin
          count_d = rdata;
        end
      end
      default: count_d = bin_valid_q[addr_q] ? rdata : '0;
    endcase
  end

  assign mem_req.we    = do_update && (op_q == chps_pkg::OP_ADD);
  assign mem_req.addr  = addr_q;
  assign mem_req.wdata = count_d;

  chps_bin_mem u_bin_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chps_pkg::ST_IDLE;
      chan_q      <= chps_pkg::CH_RED;
      op_q        <= chps_pkg::OP_READ;
      bin_valid_q <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        chan_q <= chps_pkg::chan_e'(cfg_wdata_i);
      end
      if (accept) begin
        op_q <= op_in;
      end
      if (do_update) begin
        if (op_q == chps_pkg::OP_CLEAR) begin
          bin_valid_q <= '0;
          peak_q      <= '0;
        end else if (op_q == chps_pkg::OP_ADD) begin
          bin_valid_q[addr_q] <= 1'b1;
          if (count_d > peak_q) begin
            peak_q <= count_d;
          end
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= addr_in;
    end
    if (do_update) begin
      count_q <= count_d;
    end
    if (load_out) begin
      bin_count_q  <= chps_pkg::clip_out(count_q);
      peak_count_q <= chps_pkg::clip_out(peak_q);
      axis_scale_q <= chps_pkg::decade_scale(peak_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_count_o  = bin_count_q;
  assign peak_count_o = peak_count_q;
  assign axis_scale_o = axis_scale_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chps_pkg::ST_OUT && op_q == chps_pkg::OP_ADD) |-> count_q <= peak_q)
    else $error("Peak is below the count of the bin just hit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_update && op_q == chps_pkg::OP_CLEAR) |=> (peak_q == '0 && bin_valid_q == '0))
    else $error("Clear left a bin or the peak set.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == chps_pkg::ST_OUT)
    else $error("Result raised outside the output step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> axis_scale_o != '0)
    else $error("Axis scale is zero on a valid result.");

endmodule

FILE: sim/channel_histogram_peak_scale_unit_tb.sv
module channel_histogram_peak_scale_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chps_pkg::*;

  localparam logic [1:0] FuncSpare = 2'd3;
  localparam int unsigned IdlePercent = 35;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DecadeHits = 260;
  localparam int unsigned PhaseItems = 70;

  typedef struct packed {
    logic [23:0] count;
    logic [23:0] peak;
    logic [16:0] scale;
  } bin_report_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [23:0] pixel_rgb_i;
  logic [7:0]  bin_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [23:0] bin_count_o;
  logic [23:0] peak_count_o;
  logic [16:0] axis_scale_o;

  logic [23:0] hist_bins [256];
  bit          hist_hit [256];
  logic [23:0] hist_peak;
  chan_e       hist_mode;
  bin_report_t pending_reports [$];

  int unsigned error_count;
  bit          no_idle;
  int unsigned hold_start;
  int unsigned hold_seen;
  int unsigned hold_left;

  channel_histogram_peak_scale_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .pixel_rgb_i  (pixel_rgb_i),
    .bin_index_i  (bin_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bin_count_o  (bin_count_o),
    .peak_count_o (peak_count_o),
    .axis_scale_o (axis_scale_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] pick_bin(input chan_e mode, input logic [23:0] rgb);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    case (mode)
      CH_RED:   return rgb[23:16];
      CH_GREEN: return rgb[15:8];
      CH_BLUE:  return rgb[7:0];
      default:  return 8'((r * 11 + g * 16 + b * 5) / 32);
    endcase
  endfunction

  function automatic logic [16:0] axis_decade(input logic [23:0] peak);
    longint unsigned p;
    longint unsigned s;
    p = peak;
    s = 1;
    while (p > 255) begin
      p = p / 10;
      s = s * 10;
    end
    if (s > 100000) begin
      s = 100000;
    end
    return 17'(s);
  endfunction

  function automatic bin_report_t histogram_step(input logic [1:0] func,
                                                 input logic [23:0] rgb,
                                                 input logic [7:0] idx);
    bin_report_t rep;
    logic [7:0]  b;
    logic [23:0] cnt;
    cnt = '0;
    if (func == OP_CLEAR) begin
      foreach (hist_hit[i]) begin
        hist_hit[i] = 1'b0;
      end
      hist_peak = '0;
    end else if (func == OP_ADD) begin
      b = pick_bin(hist_mode, rgb);
      if (hist_hit[b]) begin
        cnt = hist_bins[b];
        if (cnt != CountLimit) begin
          cnt = cnt + 24'd1;
        end
      end else begin
        cnt = 24'd1;
        hist_hit[b] = 1'b1;
      end
      hist_bins[b] = cnt;
      if (cnt > hist_peak) begin
        hist_peak = cnt;
      end
    end else begin
      cnt = hist_hit[idx] ? hist_bins[idx] : 24'd0;
    end
    rep.count = cnt;
    rep.peak  = hist_peak;
    rep.scale = axis_decade(hist_peak);
    return rep;
  endfunction

  task automatic log_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    bin_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        log_error($sformatf("result with nothing expected, count %0d", bin_count_o));
      end else begin
        want = pending_reports.pop_front();
        if (bin_count_o !== want.count) begin
          log_error($sformatf("bin_count %0d, expected %0d", bin_count_o, want.count));
        end
        if (peak_count_o !== want.peak) begin
          log_error($sformatf("peak_count %0d, expected %0d", peak_count_o, want.peak));
        end
        if (axis_scale_o !== want.scale) begin
          log_error($sformatf("axis_scale %0d, expected %0d", axis_scale_o, want.scale));
        end
      end
    end
    if (hold_start != hold_seen) begin
      hold_seen = hold_start;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= IdlePercent);
    end
  end

  task automatic send_item(input logic [1:0] func, input logic [23:0] rgb,
                           input logic [7:0] idx);
    if (!no_idle && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < IdlePercent);
    end
    in_valid_i  <= 1'b1;
    func_i      <= func;
    pixel_rgb_i <= rgb;
    bin_index_i <= idx;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pending_reports.push_back(histogram_step(func, rgb, idx));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic set_channel(input chan_e mode);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    hist_mode = mode;
  endtask

  task automatic test_empty_reads();
    send_item(OP_READ, 24'hFFFFFF, 8'h00);
    send_item(OP_READ, 24'h000000, 8'hFF);
    send_item(FuncSpare, 24'($urandom), 8'h80);
    send_item(OP_CLEAR, 24'($urandom), 8'($urandom));
  endtask

  task automatic test_channel_modes();
    chan_e modes [4];
    modes = '{CH_RED, CH_GREEN, CH_BLUE, CH_GRAY};
    foreach (modes[m]) begin
      set_channel(modes[m]);
      send_item(OP_ADD, 24'hFFFFFF, 8'($urandom));
      send_item(OP_ADD, 24'h000000, 8'($urandom));
      send_item(OP_ADD, 24'hA55AC3, 8'($urandom));
      send_item(OP_READ, 24'($urandom), 8'hFF);
    end
    send_item(OP_CLEAR, 24'h000000, 8'h00);
  endtask

  task automatic test_peak_decades();
    no_idle <= 1'b1;
    set_channel(CH_GRAY);
    repeat (DecadeHits) begin
      send_item(OP_ADD, 24'h2A2A2A, 8'($urandom));
    end
    send_item(OP_READ, 24'($urandom), 8'h2A);
    send_item(OP_CLEAR, 24'($urandom), 8'($urandom));
    no_idle <= 1'b0;
  endtask

  task automatic test_output_stall();
    wait_drained();
    no_idle    <= 1'b1;
    hold_start <= hold_start + 1;
    repeat (12) begin
      send_item(OP_ADD, 24'($urandom), 8'($urandom));
    end
    no_idle <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_mix();
    chan_e       phase_modes [5];
    int unsigned pick;
    logic [7:0]  hot;
    phase_modes = '{CH_GRAY, CH_RED, CH_BLUE, CH_GREEN, CH_GRAY};
    foreach (phase_modes[p]) begin
      set_channel(phase_modes[p]);
      no_idle <= (p == 2);
      repeat (PhaseItems) begin
        pick = $urandom_range(99);
        hot  = 8'($urandom_range(3) * 64 + 7);
        if (pick < 45) begin
          send_item(OP_ADD, 24'($urandom), 8'($urandom));
        end else if (pick < 65) begin
          send_item(OP_ADD, {hot, hot, hot}, 8'($urandom));
        end else if (pick < 80) begin
          send_item(OP_READ, 24'($urandom), 8'($urandom));
        end else if (pick < 90) begin
          send_item(OP_READ, 24'($urandom), hot);
        end else if (pick < 95) begin
          send_item(FuncSpare, 24'($urandom), hot);
        end else begin
          send_item(OP_CLEAR, 24'($urandom), 8'($urandom));
        end
      end
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    func_i      = '0;
    pixel_rgb_i = '0;
    bin_index_i = '0;
    out_ready_i = 1'b0;
    error_count = 0;
    no_idle     = 1'b0;
    hold_start  = 0;
    hold_seen   = 0;
    hold_left   = 0;
    foreach (hist_bins[i]) begin
      hist_bins[i] = '0;
      hist_hit[i]  = 1'b0;
    end
    hist_peak = '0;
    hist_mode = CH_RED;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_reads();
    test_channel_modes();
    test_peak_decades();
    test_output_stall();
    test_random_mix();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
